// File: hdl/swl_pkg.sv
// ---------------------------------------------------------------------------
// swl_pkg
// Shared types, character codes and small decode functions for the
// shell word lexer.
// ---------------------------------------------------------------------------
package swl_pkg;

    typedef enum logic [3:0] {
        TK_EOF     = 4'd0,
        TK_NONE    = 4'd1,
        TK_SPACE   = 4'd2,
        TK_ARG     = 4'd3,
        TK_DQ      = 4'd4,
        TK_SQ      = 4'd5,
        TK_FLAG    = 4'd6,
        TK_LFLAG   = 4'd7,
        TK_VAR     = 4'd8,
        TK_PIPEIN  = 4'd9,
        TK_PIPEOUT = 4'd10,
        TK_SUBPROG = 4'd11
    } t_tok;

    typedef enum logic [2:0] {
        SS_NEXT  = 3'd0,
        SS_ESC   = 3'd1,
        SS_HEXHI = 3'd2,
        SS_HEXLO = 3'd3,
        SS_SHORT = 3'd4,
        SS_LONG  = 3'd5,
        SS_VNAME = 3'd6
    } t_sub;

    typedef enum logic [1:0] {
        ACT_DONE   = 2'd0,
        ACT_AGAIN  = 2'd1,
        ACT_ERR    = 2'd2,
        ACT_ERREOF = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NOTIMPL  = 3'd1,
        ERR_UNKSTATE = 3'd2,
        ERR_ESCAPE   = 3'd3,
        ERR_TOKEN    = 3'd4,
        ERR_EOF      = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        TE_NONE    = 2'd0,
        TE_KEEP    = 2'd1,
        TE_CONSUME = 2'd2
    } t_end;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_DQUOTE = 8'h22;
    localparam logic [7:0] C_SQUOTE = 8'h27;
    localparam logic [7:0] C_DASH   = 8'h2D;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_BTICK  = 8'h60;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LOW_X  = 8'h78;
    localparam logic [7:0] C_UP_X   = 8'h58;
    localparam logic [7:0] C_UNDER  = 8'h5F;

    typedef struct packed {
        t_tok       token_type;
        t_sub       sub_state;
        logic [7:0] hex_byte;
    } t_state;

    typedef struct packed {
        t_act       action;
        t_err       error_code;
        logic       char_valid;
        logic [7:0] char_out;
        t_tok       token_kind;
        t_end       token_end;
    } t_result;

    localparam t_state ST_RESET = '{token_type: TK_NONE, sub_state: SS_NEXT,
                                    hex_byte: 8'h00};

    function automatic logic is_blank(input logic [7:0] c);
        return (c == C_SPACE) || (c == C_TAB);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == C_UNDER);
    endfunction

    // non-hex characters decode as zero
    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

endpackage

// File: hdl/swl_step.sv
// ---------------------------------------------------------------------------
// swl_step
// Next-state and result decode for one lexer character.
// ---------------------------------------------------------------------------
module swl_step import swl_pkg::*; (
    input  t_state     i_state,
    input  logic       i_kind,
    input  logic [7:0] i_char,
    output t_state     o_next_state,
    output t_result    o_result
);

    t_state     n;
    t_result    res;
    logic [7:0] c;
    logic       term_hit;
    logic       blank_or_nul;
    logic [7:0] hex_full;

    assign c            = i_char;
    assign blank_or_nul = is_blank(c) || (c == C_NUL);
    assign term_hit     = (i_state.token_type == TK_SQ) ? (c == C_SQUOTE)
                                                         : (c == C_DQUOTE);
    assign hex_full     = {i_state.hex_byte[7:4], nibble(c)};

    always_comb begin
        n   = i_state;
        res = '{action: ACT_DONE, error_code: ERR_NONE, char_valid: 1'b0,
                char_out: 8'h00, token_kind: TK_NONE, token_end: TE_NONE};

        if (i_kind == KIND_RESTART) begin
            n = ST_RESET;
        end else begin
            unique case (i_state.token_type)
                TK_NONE: begin
                    n.sub_state = SS_NEXT;
                    priority if (c == C_DQUOTE) begin
                        n.token_type = TK_DQ;
                    end else if (c == C_SQUOTE) begin
                        n.token_type = TK_SQ;
                    end else if (c == C_DASH) begin
                        n.token_type = TK_FLAG;
                    end else if (c == C_DOLLAR) begin
                        n.token_type = TK_VAR;
                    end else if (c == C_LT) begin
                        n.token_type   = TK_PIPEIN;
                        res.action     = ACT_ERR;
                        res.error_code = ERR_NOTIMPL;
                    end else if (c == C_GT) begin
                        n.token_type   = TK_PIPEOUT;
                        res.action     = ACT_ERR;
                        res.error_code = ERR_NOTIMPL;
                    end else if (c == C_BTICK) begin
                        n.token_type   = TK_SUBPROG;
                        res.action     = ACT_ERR;
                        res.error_code = ERR_NOTIMPL;
                    end else if (is_blank(c)) begin
                        n.token_type   = TK_SPACE;
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                    end else if (c == C_NUL) begin
                        n.token_type   = TK_EOF;
                        res.char_valid = 1'b1;
                    end else begin
                        n.token_type = TK_ARG;
                        res.action   = ACT_AGAIN;
                    end
                end
                TK_ARG: begin
                    priority if (c == C_BSLASH) begin
                        n.sub_state = SS_ESC;
                    end else if (i_state.sub_state == SS_ESC) begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                        n.sub_state    = SS_NEXT;
                    end else if (blank_or_nul || c == C_DQUOTE || c == C_SQUOTE ||
                                 c == C_DOLLAR || c == C_LT || c == C_GT ||
                                 c == C_BTICK) begin
                        res.token_end = TE_KEEP;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                    end
                end
                TK_DQ, TK_SQ: begin
                    priority if (c == C_BSLASH) begin
                        n.sub_state = SS_ESC;
                    end else if (i_state.sub_state == SS_ESC) begin
                        if (c == C_LOW_X || c == C_UP_X) begin
                            n.sub_state = SS_HEXHI;
                        end else begin
                            res.action     = ACT_ERR;
                            res.error_code = ERR_ESCAPE;
                        end
                    end else if (i_state.sub_state == SS_HEXHI) begin
                        n.hex_byte  = {nibble(c), 4'h0};
                        n.sub_state = SS_HEXLO;
                    end else if (i_state.sub_state == SS_HEXLO) begin
                        n.hex_byte     = hex_full;
                        res.char_valid = 1'b1;
                        res.char_out   = hex_full;
                        n.sub_state    = SS_NEXT;
                    end else if (term_hit) begin
                        res.token_end = TE_CONSUME;
                    end else if (c == C_NUL) begin
                        res.action     = ACT_ERR;
                        res.error_code = ERR_EOF;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                    end
                end
                TK_FLAG: begin
                    if (i_state.sub_state == SS_NEXT) begin
                        priority if (c == C_DASH) begin
                            n.token_type = TK_LFLAG;
                            res.action   = ACT_AGAIN;
                        end else if (is_word(c)) begin
                            n.sub_state = SS_SHORT;
                            res.action  = ACT_AGAIN;
                        end else if (c == C_NUL) begin
                            res.action     = ACT_ERR;
                            res.error_code = ERR_EOF;
                        end else begin
                            res.char_valid = 1'b1;
                            res.char_out   = c;
                            res.action     = ACT_ERR;
                            res.error_code = ERR_TOKEN;
                        end
                    end else if (i_state.sub_state == SS_SHORT) begin
                        priority if (is_word(c)) begin
                            res.char_valid = 1'b1;
                            res.char_out   = c;
                        end else if (blank_or_nul) begin
                            res.token_end = TE_KEEP;
                        end else begin
                            res.char_valid = 1'b1;
                            res.char_out   = c;
                            res.action     = ACT_ERR;
                            res.error_code = ERR_TOKEN;
                        end
                    end
                end
                TK_LFLAG: begin
                    priority if (i_state.sub_state == SS_NEXT) begin
                        n.sub_state = SS_LONG;
                    end else if (blank_or_nul && i_state.sub_state != SS_LONG) begin
                        res.action = ACT_ERREOF;
                    end else if (blank_or_nul) begin
                        res.token_end = TE_KEEP;
                    end else if (is_word(c) || c == C_DASH) begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                        res.action     = ACT_ERR;
                        res.error_code = ERR_TOKEN;
                    end
                end
                TK_VAR: begin
                    priority if (i_state.sub_state == SS_NEXT) begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                        n.sub_state    = SS_VNAME;
                    end else if (blank_or_nul && i_state.sub_state != SS_VNAME) begin
                        res.action = ACT_ERREOF;
                    end else if (blank_or_nul) begin
                        res.token_end = TE_KEEP;
                    end else if (is_word(c)) begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                        res.action     = ACT_ERR;
                        res.error_code = ERR_TOKEN;
                    end
                end
                TK_SPACE: begin
                    if (!is_blank(c)) begin
                        res.token_end = TE_KEEP;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_out   = c;
                    end
                end
                TK_EOF: begin
                    // sticky until restart
                end
                default: begin
                    res.action     = ACT_ERR;
                    res.error_code = ERR_UNKSTATE;
                    n              = ST_RESET;
                end
            endcase

            // kind is reported before the end-of-token return to idle
            res.token_kind = n.token_type;
            if (res.token_end != TE_NONE) begin
                if (res.token_end == TE_KEEP) begin
                    res.action = ACT_AGAIN;
                end
                n.token_type = TK_NONE;
                n.sub_state  = SS_NEXT;
            end
        end
    end

    assign o_next_state = n;
    assign o_result     = res;

endmodule

// File: hdl/shell_word_lexer_step.sv
// ---------------------------------------------------------------------------
// shell_word_lexer_step
// Shell word lexer: one character word in, one result word out.
// ---------------------------------------------------------------------------
// Takes one character word per cycle while the output is not stalled. A word
// sits in an input register, is decoded against the token state and lands in
// a result register; a stalled output holds the word in the input register.
// The only feedback loop is the token state register, which is updated by the
// same decode that writes the result register. A held result does not block
// intake: the input register keeps taking words until both stages are full.
module shell_word_lexer_step import swl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_kind,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_action,
    output logic [2:0] o_error_code,
    output logic       o_char_valid,
    output logic [7:0] o_char_out,
    output logic [3:0] o_token_kind,
    output logic [1:0] o_token_end
);

    logic       r_in_valid;
    logic       r_kind;
    logic [7:0] r_char;
    logic       r_out_valid;
    t_result    r_res;
    t_state     r_state;

    t_state     n_state;
    t_result    n_res;
    logic       out_free;
    logic       in_take;
    logic       step_go;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;
    assign step_go  = r_in_valid && out_free;

    swl_step u_step (
        .i_state      (r_state),
        .i_kind       (r_kind),
        .i_char       (r_char),
        .o_next_state (n_state),
        .o_result     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step_go) begin
                r_in_valid <= 1'b0;
            end
            if (step_go) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_char <= i_char_in;
        end
        if (step_go) begin
            r_res <= n_res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_action     = r_res.action;
    assign o_error_code = r_res.error_code;
    assign o_char_valid = r_res.char_valid;
    assign o_char_out   = r_res.char_out;
    assign o_token_kind = r_res.token_kind;
    assign o_token_end  = r_res.token_end;

endmodule

// File: hdl/swl_checker.sv
// ---------------------------------------------------------------------------
// swl_checker
// Port-level checks on the lexer result stream.
// ---------------------------------------------------------------------------
module swl_checker import swl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_valid,
    input  logic       i_stall,
    input  logic [1:0] o_action,
    input  logic [2:0] o_error_code,
    input  logic       o_char_valid,
    input  logic [7:0] o_char_out,
    input  logic [3:0] o_token_kind,
    input  logic [1:0] o_token_end
);

    // token end without consuming must ask for the same char again
    a_end_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_end == TE_KEEP) |-> (o_action == ACT_AGAIN))
        else $error("token end without consume but action is not re-feed");

    // any error code rides with the plain error action
    a_err_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code != ERR_NONE) |-> (o_action == ACT_ERR))
        else $error("error code set with wrong action");

    // unknown state drops the lexer back to idle
    a_unk_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error_code == ERR_UNKSTATE) |-> (o_token_kind == TK_NONE))
        else $error("unknown state error did not report idle");

    a_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_char_out == 8'h00))
        else $error("char_out nonzero without char_valid");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_char_out) &&
                                  $stable(o_action) && $stable(o_token_end)))
        else $error("stalled result word changed");

endmodule

bind shell_word_lexer_step swl_checker u_swl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_action     (o_action),
    .o_error_code (o_error_code),
    .o_char_valid (o_char_valid),
    .o_char_out   (o_char_out),
    .o_token_kind (o_token_kind),
    .o_token_end  (o_token_end)
);

// File: tb/tb_shell_word_lexer_step.sv
// ---------------------------------------------------------------------------
// tb_shell_word_lexer_step
// Self-checking bench for the shell word lexer. Character words are fed
// through the valid/stall input channel, a local model of the lexer predicts
// each result word, and a checker compares every accepted result field by
// field in order. Directed cases cover idle token selection, not-implemented
// and unknown-state errors, string escapes and flag errors. Random command
// lines and random noise follow. Both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_shell_word_lexer_step;
    import swl_pkg::*;

    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_LOW_A = "a";
    localparam logic [7:0] CH_LOW_F = "f";
    localparam logic [7:0] CH_LOW_Z = "z";
    localparam logic [7:0] CH_UP_A  = "A";
    localparam logic [7:0] CH_UP_F  = "F";
    localparam logic [7:0] CH_UP_Z  = "Z";
    localparam logic [7:0] CH_BANG  = "!";
    localparam string HEX_SET = "0123456789abcdefABCDEF";
    localparam logic [7:0] SPECIAL_CHARS [14] = '{C_NUL, C_TAB, C_SPACE, C_DQUOTE,
        C_SQUOTE, C_DASH, C_DOLLAR, C_LT, C_GT, C_BTICK, C_BSLASH, C_LOW_X, C_UP_X,
        C_UNDER};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic       i_kind;
    logic [7:0] i_char_in;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_action;
    logic [2:0] o_error_code;
    logic       o_char_valid;
    logic [7:0] o_char_out;
    logic [3:0] o_token_kind;
    logic [1:0] o_token_end;

    // lexer model state
    t_tok       lex_tok = TK_NONE;
    t_sub       lex_sub = SS_NEXT;
    logic [7:0] lex_hex = 8'h00;

    t_result expected_results[$];
    int      mismatch_count = 0;
    int      words_sent = 0;
    int      src_gap_max = 0;
    int      sink_stall_max = 0;

    shell_word_lexer_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_char_in   (i_char_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_action    (o_action),
        .o_error_code(o_error_code),
        .o_char_valid(o_char_valid),
        .o_char_out  (o_char_out),
        .o_token_kind(o_token_kind),
        .o_token_end (o_token_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_gap_char(input logic [7:0] c);
        return c inside {C_SPACE, C_TAB};
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return c inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z], [CH_0:CH_9], C_UNDER};
    endfunction

    // anything that is not a hex digit reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c inside {[CH_0:CH_9]}) return c[3:0];
        if (c inside {[CH_LOW_A:CH_LOW_F], [CH_UP_A:CH_UP_F]}) return c[3:0] + 4'd9;
        return 4'h0;
    endfunction

    function automatic logic [7:0] pick_name_char();
        int n;
        n = $urandom_range(0, 62);
        if (n < 26) return CH_LOW_A + 8'(n);
        if (n < 52) return CH_UP_A + 8'(n - 26);
        if (n < 62) return CH_0 + 8'(n - 52);
        return C_UNDER;
    endfunction

    function automatic logic [7:0] pick_hex_char();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return HEX_SET[$urandom_range(0, 21)];
    endfunction

    // Advances the lexer model by one word and returns the result it gives.
    function automatic t_result lex_step(input logic kind, input logic [7:0] c);
        t_result    r;
        t_end       fin;
        logic [7:0] term;
        logic       stop;
        r = '{action: ACT_DONE, error_code: ERR_NONE, char_valid: 1'b0,
              char_out: 8'h00, token_kind: TK_NONE, token_end: TE_NONE};
        fin = TE_NONE;
        if (kind == KIND_RESTART) begin
            lex_tok = TK_NONE;
            lex_sub = SS_NEXT;
            lex_hex = 8'h00;
            return r;
        end
        stop = is_gap_char(c) || (c == C_NUL);
        case (lex_tok)
            TK_NONE: begin
                lex_sub = SS_NEXT;
                if (c == C_DQUOTE) lex_tok = TK_DQ;
                else if (c == C_SQUOTE) lex_tok = TK_SQ;
                else if (c == C_DASH) lex_tok = TK_FLAG;
                else if (c == C_DOLLAR) lex_tok = TK_VAR;
                else if (c inside {C_LT, C_GT, C_BTICK}) begin
                    lex_tok = (c == C_LT) ? TK_PIPEIN : (c == C_GT) ? TK_PIPEOUT : TK_SUBPROG;
                    r.action = ACT_ERR;
                    r.error_code = ERR_NOTIMPL;
                end else if (is_gap_char(c)) begin
                    lex_tok = TK_SPACE;
                    r.char_valid = 1'b1;
                    r.char_out = c;
                end else if (c == C_NUL) begin
                    lex_tok = TK_EOF;
                    r.char_valid = 1'b1;
                end else begin
                    lex_tok = TK_ARG;
                    r.action = ACT_AGAIN;
                end
            end
            TK_ARG: begin
                if (c == C_BSLASH) begin
                    lex_sub = SS_ESC;
                end else if (lex_sub == SS_ESC) begin
                    r.char_valid = 1'b1;
                    r.char_out = c;
                    lex_sub = SS_NEXT;
                end else if (stop || c inside {C_DQUOTE, C_SQUOTE, C_DOLLAR, C_LT, C_GT,
                                               C_BTICK}) begin
                    fin = TE_KEEP;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_out = c;
                end
            end
            TK_DQ, TK_SQ: begin
                term = (lex_tok == TK_SQ) ? C_SQUOTE : C_DQUOTE;
                if (c == C_BSLASH) begin
                    lex_sub = SS_ESC;
                end else if (lex_sub == SS_ESC) begin
                    if (c inside {C_LOW_X, C_UP_X}) begin
                        lex_sub = SS_HEXHI;
                    end else begin
                        r.action = ACT_ERR;
                        r.error_code = ERR_ESCAPE;
                    end
                end else if (lex_sub == SS_HEXHI) begin
                    lex_hex = {hex_value(c), 4'h0};
                    lex_sub = SS_HEXLO;
                end else if (lex_sub == SS_HEXLO) begin
                    lex_hex[3:0] = hex_value(c);
                    r.char_valid = 1'b1;
                    r.char_out = lex_hex;
                    lex_sub = SS_NEXT;
                end else if (c == term) begin
                    fin = TE_CONSUME;
                end else if (c == C_NUL) begin
                    r.action = ACT_ERR;
                    r.error_code = ERR_EOF;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_out = c;
                end
            end
            TK_FLAG: begin
                if (lex_sub == SS_NEXT) begin
                    if (c == C_DASH) begin
                        lex_tok = TK_LFLAG;
                        r.action = ACT_AGAIN;
                    end else if (is_name_char(c)) begin
                        lex_sub = SS_SHORT;
                        r.action = ACT_AGAIN;
                    end else if (c == C_NUL) begin
                        r.action = ACT_ERR;
                        r.error_code = ERR_EOF;
                    end else begin
                        r.char_valid = 1'b1;
                        r.char_out = c;
                        r.action = ACT_ERR;
                        r.error_code = ERR_TOKEN;
                    end
                end else if (lex_sub == SS_SHORT) begin
                    if (stop) begin
                        fin = TE_KEEP;
                    end else begin
                        r.char_valid = 1'b1;
                        r.char_out = c;
                        if (!is_name_char(c)) begin
                            r.action = ACT_ERR;
                            r.error_code = ERR_TOKEN;
                        end
                    end
                end
            end
            TK_LFLAG, TK_VAR: begin
                if (lex_sub == SS_NEXT) begin
                    // long flag skips the second dash; a variable keeps its first byte
                    if (lex_tok == TK_LFLAG) begin
                        lex_sub = SS_LONG;
                    end else begin
                        r.char_valid = 1'b1;
                        r.char_out = c;
                        lex_sub = SS_VNAME;
                    end
                end else if (stop && lex_sub != SS_LONG && lex_sub != SS_VNAME) begin
                    r.action = ACT_ERREOF;
                end else if (stop) begin
                    fin = TE_KEEP;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_out = c;
                    if (!(is_name_char(c) || (lex_tok == TK_LFLAG && c == C_DASH))) begin
                        r.action = ACT_ERR;
                        r.error_code = ERR_TOKEN;
                    end
                end
            end
            TK_SPACE: begin
                if (!is_gap_char(c)) begin
                    fin = TE_KEEP;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_out = c;
                end
            end
            TK_EOF: ;
            default: begin
                r.action = ACT_ERR;
                r.error_code = ERR_UNKSTATE;
                lex_tok = TK_NONE;
                lex_sub = SS_NEXT;
                lex_hex = 8'h00;
            end
        endcase
        r.token_kind = lex_tok;
        r.token_end = fin;
        if (fin != TE_NONE) begin
            if (fin == TE_KEEP) r.action = ACT_AGAIN;
            lex_tok = TK_NONE;
            lex_sub = SS_NEXT;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR at %0t: %s is %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    // Sends one word, waits for it to be taken, and queues its prediction.
    task automatic send_word(input logic kind, input logic [7:0] c, output t_result want);
        int   gap;
        logic held;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_kind    <= kind;
        i_char_in <= c;
        do begin
            @(negedge i_clk);
            held = o_stall;
            @(posedge i_clk);
        end while (held);
        want = lex_step(kind, c);
        expected_results.push_back(want);
        words_sent++;
    endtask

    // Feeds a character the way a caller would: again while asked to re-feed.
    task automatic lex_byte(input logic [7:0] c);
        t_result r;
        int      tries;
        tries = 0;
        do begin
            send_word(KIND_CHAR, c, r);
            tries++;
        end while (r.action == ACT_AGAIN && tries < 4);
    endtask

    task automatic lex_text(input string s);
        for (int k = 0; k < s.len(); k++) lex_byte(s[k]);
    endtask

    task automatic restart_lexer();
        t_result r;
        send_word(KIND_RESTART, 8'($urandom_range(0, 255)), r);
    endtask

    task automatic lex_quoted(input logic [7:0] quote);
        logic [7:0] c;
        lex_byte(quote);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    lex_byte(C_BSLASH);
                    lex_byte($urandom_range(0, 1) ? C_LOW_X : C_UP_X);
                    lex_byte(pick_hex_char());
                    lex_byte(pick_hex_char());
                end
                2: begin
                    // bad escape stays in escape until a valid x arrives
                    do c = 8'($urandom_range(1, 255));
                    while (c inside {C_LOW_X, C_UP_X, C_BSLASH});
                    lex_byte(C_BSLASH);
                    lex_byte(c);
                    lex_byte(C_LOW_X);
                    lex_byte(pick_hex_char());
                    lex_byte(pick_hex_char());
                end
                default: begin
                    do c = 8'($urandom_range(1, 255));
                    while (c == quote || c == C_BSLASH);
                    lex_byte(c);
                end
            endcase
        end
        lex_byte(quote);
    endtask

    task automatic test_idle_tokens();
        src_gap_max = 2;
        sink_stall_max = 2;
        restart_lexer();
        lex_byte(C_NUL);
        lex_byte(8'hFF);
        restart_lexer();
        lex_byte(C_LT);
        lex_byte(CH_LOW_A);
        lex_byte(C_GT);
        restart_lexer();
        lex_byte(C_BTICK);
        lex_byte(C_TAB);
    endtask

    task automatic test_quoted_escapes();
        lex_text("\"\\x4g\\5X0F\"");
        lex_byte(C_SQUOTE);
        lex_byte(C_NUL);
        restart_lexer();
    endtask

    task automatic test_flag_error();
        lex_byte(C_DASH);
        lex_byte(CH_BANG);
        restart_lexer();
    endtask

    task automatic test_random_lines();
        while (words_sent < 330) begin
            case ($urandom_range(0, 3))
                0: begin src_gap_max = 0;  sink_stall_max = 0;  end
                1: begin src_gap_max = 10; sink_stall_max = 0;  end
                2: begin src_gap_max = 0;  sink_stall_max = 10; end
                default: begin src_gap_max = 10; sink_stall_max = 10; end
            endcase
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 5))
                    0: begin
                        lex_byte(pick_name_char());
                        repeat ($urandom_range(0, 6)) begin
                            if ($urandom_range(0, 5) == 0) begin
                                lex_byte(C_BSLASH);
                                lex_byte(8'($urandom_range(0, 255)));
                            end else begin
                                lex_byte(pick_name_char());
                            end
                        end
                    end
                    1: lex_quoted(C_DQUOTE);
                    2: lex_quoted(C_SQUOTE);
                    3, 4: begin
                        lex_byte(C_DASH);
                        if ($urandom_range(3, 4) == 4) lex_byte(C_DASH);
                        repeat ($urandom_range(1, 5)) lex_byte(pick_name_char());
                    end
                    default: begin
                        lex_byte(C_DOLLAR);
                        repeat ($urandom_range(1, 5)) lex_byte(pick_name_char());
                    end
                endcase
                if ($urandom_range(0, 7) != 0)
                    repeat ($urandom_range(1, 2)) lex_byte($urandom_range(0, 1) ? C_SPACE : C_TAB);
            end
            lex_byte(C_NUL);
            if ($urandom_range(0, 3) == 0) lex_byte(8'($urandom_range(0, 255)));
            restart_lexer();
        end
    endtask

    task automatic test_noise();
        t_result    r;
        logic       kind;
        logic [7:0] c;
        src_gap_max = 10;
        sink_stall_max = 10;
        while (words_sent < 440) begin
            kind = ($urandom_range(0, 11) == 0) ? KIND_RESTART : KIND_CHAR;
            c = $urandom_range(0, 1) ? SPECIAL_CHARS[$urandom_range(0, 13)]
                                     : 8'($urandom_range(0, 255));
            send_word(kind, c, r);
        end
    endtask

    // result side: random stall before taking each result word
    initial begin : result_sink
        int   wait_cycles;
        logic took;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            wait_cycles = $urandom_range(0, sink_stall_max);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do begin
                @(negedge i_clk);
                took = o_valid;
                @(posedge i_clk);
            end while (!took);
        end
    end

    // inputs are stable between the negedge and the next rising edge
    always @(negedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with none pending, action", 32'(o_action), 0);
            end else begin
                want = expected_results.pop_front();
                if (o_action != want.action)
                    report_mismatch("action", 32'(o_action), 32'(want.action));
                if (o_error_code != want.error_code)
                    report_mismatch("error_code", 32'(o_error_code), 32'(want.error_code));
                if (o_char_valid != want.char_valid)
                    report_mismatch("char_valid", 32'(o_char_valid), 32'(want.char_valid));
                if (o_char_out != want.char_out)
                    report_mismatch("char_out", 32'(o_char_out), 32'(want.char_out));
                if (o_token_kind != want.token_kind)
                    report_mismatch("token_kind", 32'(o_token_kind), 32'(want.token_kind));
                if (o_token_end != want.token_end)
                    report_mismatch("token_end", 32'(o_token_end), 32'(want.token_end));
            end
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_kind    <= KIND_CHAR;
        i_char_in <= C_NUL;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_tokens();
        test_quoted_escapes();
        test_flag_error();
        test_random_lines();
        test_noise();

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
